>>> rtl/shjc_pkg.sv
// Package for the sprite height jitter check: widths, reset values and register indexes.
package shjc_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned ROW_W    = 8;
    localparam int unsigned HEIGHT_W = 9;
    localparam int unsigned RANGE_W  = 8;
    localparam int unsigned SUM_W    = 14;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned PROD_W   = CFG_W + RANGE_W;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic [CFG_W-1:0] ALPHA_THR_RST = 8'd24;
    localparam logic [CFG_W-1:0] IGN_RANGE_RST = 8'd3;
    localparam logic [CFG_W-1:0] RATIO_RST     = 8'd7;

    localparam int unsigned CELL_HEIGHT_MAX_DEF = 256;
    localparam int unsigned MAX_FRAMES_DEF      = 64;

    typedef enum logic [1:0] {
        CFG_ALPHA_THR = 2'd0,
        CFG_IGN_RANGE = 2'd1,
        CFG_RATIO     = 2'd2
    } t_cfg_idx;

endpackage

>>> rtl/shjc_if.sv
// Channel interfaces of the sprite height jitter check: pixel, result and register write.
interface shjc_pix_if;
    logic                          valid;
    logic                          ready;
    logic [shjc_pkg::PIX_W-1:0]    alpha;
    logic [shjc_pkg::ROW_W-1:0]    cell_row;
    logic                          in_sheet;
    logic                          last_in_cell;
    logic                          last_in_animation;

    modport source (output valid, alpha, cell_row, in_sheet, last_in_cell,
                    last_in_animation, input ready);
    modport sink   (input valid, alpha, cell_row, in_sheet, last_in_cell,
                    last_in_animation, output ready);
endinterface

interface shjc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          measured;
    logic [shjc_pkg::RANGE_W-1:0]  height_range;
    logic [shjc_pkg::SUM_W-1:0]    total_change;
    logic                          jitter;
    logic [shjc_pkg::CNT_W-1:0]    frames_counted;

    modport source (output valid, measured, height_range, total_change, jitter,
                    frames_counted, input ready);
    modport sink   (input valid, measured, height_range, total_change, jitter,
                    frames_counted, output ready);
endinterface

interface shjc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    index;
    logic [shjc_pkg::CFG_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/sprite_height_jitter_check_core.sv
// Sprite height jitter check: per-cell opaque height tracking and per-animation jitter report.
//
// Takes one pixel transaction per clock while the result side keeps up: a five-stage pipeline
// with per-stage valid flags separates the pixel side from the result side. The cell tracker
// (top and bottom opaque rows) updates in the accept cycle; a closed cell then walks through
// height, animation update, range and jitter-compare stages. An animation's result is
// presented from the stage-five output register once the cell that ends it has passed stages
// one to four. Backpressure on the result channel fills only the stages that hold results:
// pixels stall once stages two to four hold three finished results behind the output register
// and a further closed cell waits in stage one. Cells without an opaque pixel are dropped
// before stage one unless they end the animation; frame count saturates at MAX_FRAMES, the
// change sum at its 14-bit maximum. Registers may be written only while no result is pending.
module sprite_height_jitter_check_core #(
    parameter int unsigned CELL_HEIGHT_MAX = shjc_pkg::CELL_HEIGHT_MAX_DEF,
    parameter int unsigned MAX_FRAMES      = shjc_pkg::MAX_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shjc_pix_if.sink    i_pix,
    shjc_cfg_if.sink    i_cfg,
    shjc_res_if.source  o_res
);

    localparam int unsigned HW = shjc_pkg::HEIGHT_W;
    localparam int unsigned RW = shjc_pkg::ROW_W;
    localparam int unsigned SW = shjc_pkg::SUM_W;
    localparam int unsigned CW = shjc_pkg::CNT_W;

    // ---------------------------------------------------------------- configuration
    logic [shjc_pkg::CFG_W-1:0] r_alpha_thr, r_ign_range, r_ratio;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_thr <= shjc_pkg::ALPHA_THR_RST;
            r_ign_range <= shjc_pkg::IGN_RANGE_RST;
            r_ratio     <= shjc_pkg::RATIO_RST;
        end else if (i_cfg.valid) begin
            case (shjc_pkg::t_cfg_idx'(i_cfg.index))
                shjc_pkg::CFG_ALPHA_THR: r_alpha_thr <= i_cfg.data;
                shjc_pkg::CFG_IGN_RANGE: r_ign_range <= i_cfg.data;
                shjc_pkg::CFG_RATIO:     r_ratio     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_end2;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic adv1, adv2, adv3, adv4;
    logic pix_acc;

    // A stage is free when empty or when its content moves on. Stage 2 items that do not end
    // an animation only fold into the animation state and leave without a slot downstream.
    assign rdy5 = !r_v5 || o_res.ready;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || !r_end2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign adv1 = r_v1 && rdy2;
    assign adv2 = r_v2 && (!r_end2 || rdy3);
    assign adv3 = r_v3 && rdy4;
    assign adv4 = r_v4 && rdy5;

    assign i_pix.ready = rdy1;
    assign pix_acc     = i_pix.valid && rdy1;

    // ---------------------------------------------------------------- cell tracker
    logic [RW-1:0] r_top, r_bot, n_top, n_bot;
    logic          r_has, n_has;
    logic          opaque, close_cell, evt1;
    logic [RW-1:0] upd_top, upd_bot;
    logic          upd_has;

    // Opaque pixel: inside the sheet, row inside the cell, alpha at or above threshold.
    assign opaque = i_pix.in_sheet
                 && ({1'b0, i_pix.cell_row} < HW'(CELL_HEIGHT_MAX))
                 && (i_pix.alpha >= r_alpha_thr);
    assign close_cell = i_pix.last_in_cell || i_pix.last_in_animation;

    always_comb begin
        upd_top = r_top;
        upd_bot = r_bot;
        upd_has = r_has;
        if (opaque) begin
            if (i_pix.cell_row < r_top) upd_top = i_pix.cell_row;
            if (i_pix.cell_row > r_bot) upd_bot = i_pix.cell_row;
            upd_has = 1'b1;
        end
        n_top = r_top;
        n_bot = r_bot;
        n_has = r_has;
        if (pix_acc) begin
            if (close_cell) begin
                n_top = '1;
                n_bot = '0;
                n_has = 1'b0;
            end else begin
                n_top = upd_top;
                n_bot = upd_bot;
                n_has = upd_has;
            end
        end
    end

    // Drop closed cells that carry no height unless they end the animation.
    assign evt1 = pix_acc && close_cell && (upd_has || i_pix.last_in_animation);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '1;
            r_bot <= '0;
            r_has <= 1'b0;
        end else begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_has <= n_has;
        end
    end

    // ---------------------------------------------------------------- stage 1: closed cell
    logic [RW-1:0] r_top1, r_bot1;
    logic          r_has1, r_end1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (evt1) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt1) begin
            r_top1 <= upd_top;
            r_bot1 <= upd_bot;
            r_has1 <= upd_has;
            r_end1 <= i_pix.last_in_animation;
        end
    end

    // ---------------------------------------------------------------- stage 2: cell height
    logic [HW-1:0] r_h2;
    logic          r_has2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv1) begin
            r_v2 <= 1'b1;
        end else if (adv2) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_h2   <= {1'b0, r_bot1} - {1'b0, r_top1} + HW'(1);
            r_has2 <= r_has1;
            r_end2 <= r_end1;
        end
    end

    // ---------------------------------------------------------------- stage 3: animation state
    logic [HW-1:0] r_prev, r_lo, r_hi, n_prev, n_lo, n_hi;
    logic [SW-1:0] r_sum, n_sum;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [HW-1:0] u_prev, u_lo, u_hi, diff;
    logic [SW-1:0] u_sum;
    logic [CW-1:0] u_cnt;
    logic [SW:0]   sum_wide;

    assign diff     = (r_h2 >= r_prev) ? (r_h2 - r_prev) : (r_prev - r_h2);
    assign sum_wide = {1'b0, r_sum} + (SW+1)'(diff);

    always_comb begin
        u_prev = r_prev;
        u_lo   = r_lo;
        u_hi   = r_hi;
        u_sum  = r_sum;
        u_cnt  = r_cnt;
        if (r_has2) begin
            if (r_cnt == '0) begin
                u_lo = r_h2;
                u_hi = r_h2;
            end else begin
                if (r_h2 < r_lo) u_lo = r_h2;
                if (r_h2 > r_hi) u_hi = r_h2;
                u_sum = sum_wide[SW] ? shjc_pkg::SUM_MAX : sum_wide[SW-1:0];
            end
            u_prev = r_h2;
            if (r_cnt < CW'(MAX_FRAMES)) u_cnt = r_cnt + CW'(1);
        end
        n_prev = r_prev;
        n_lo   = r_lo;
        n_hi   = r_hi;
        n_sum  = r_sum;
        n_cnt  = r_cnt;
        if (adv2) begin
            if (r_end2) begin
                n_prev = '0;
                n_lo   = '0;
                n_hi   = '0;
                n_sum  = '0;
                n_cnt  = '0;
            end else begin
                n_prev = u_prev;
                n_lo   = u_lo;
                n_hi   = u_hi;
                n_sum  = u_sum;
                n_cnt  = u_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_lo   <= '0;
            r_hi   <= '0;
            r_sum  <= '0;
            r_cnt  <= '0;
        end else begin
            r_prev <= n_prev;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
        end
    end

    // Snapshot of the animation at its end.
    logic [HW-1:0] r_lo3, r_hi3;
    logic [SW-1:0] r_sum3;
    logic [CW-1:0] r_cnt3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv2 && r_end2) begin
            r_v3 <= 1'b1;
        end else if (adv3) begin
            r_v3 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_end2) begin
            r_lo3  <= u_lo;
            r_hi3  <= u_hi;
            r_sum3 <= u_sum;
            r_cnt3 <= u_cnt;
        end
    end

    // ---------------------------------------------------------------- stage 4: range
    logic [HW-1:0]                  range_wide;
    logic [shjc_pkg::RANGE_W-1:0]   r_range4;
    logic [SW-1:0]                  r_sum4;
    logic [CW-1:0]                  r_cnt4;
    logic                           r_meas4;

    // Heights span 1..256, so the range always fits eight bits.
    assign range_wide = (r_hi3 >= r_lo3) ? (r_hi3 - r_lo3) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv3) begin
            r_v4 <= 1'b1;
        end else if (adv4) begin
            r_v4 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_range4 <= range_wide[shjc_pkg::RANGE_W-1:0];
            r_sum4   <= r_sum3;
            r_cnt4   <= r_cnt3;
            r_meas4  <= (r_cnt3 >= CW'(2));
        end
    end

    // ---------------------------------------------------------------- stage 5: jitter, output
    logic [shjc_pkg::PROD_W-1:0]    limit;
    logic [shjc_pkg::PROD_W-1:0]    twice_sum;
    logic                           jitter4;
    logic                           r_meas5, r_jit5;
    logic [shjc_pkg::RANGE_W-1:0]   r_range5;
    logic [SW-1:0]                  r_sum5;
    logic [CW-1:0]                  r_cnt5;

    assign limit     = shjc_pkg::PROD_W'(r_ratio) * shjc_pkg::PROD_W'(r_range4);
    assign twice_sum = shjc_pkg::PROD_W'({r_sum4, 1'b0});
    assign jitter4   = r_meas4 && (r_range4 > r_ign_range) && (twice_sum > limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (adv4) begin
            r_v5 <= 1'b1;
        end else if (o_res.ready) begin
            r_v5 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_meas5  <= r_meas4;
            r_jit5   <= jitter4;
            r_range5 <= r_range4;
            r_sum5   <= r_sum4;
            r_cnt5   <= r_cnt4;
        end
    end

    assign o_res.valid          = r_v5;
    assign o_res.measured       = r_meas5;
    assign o_res.height_range   = r_range5;
    assign o_res.total_change   = r_sum5;
    assign o_res.jitter         = r_jit5;
    assign o_res.frames_counted = r_cnt5;

    // ---------------------------------------------------------------- assertions
    a_jitter_needs_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (!r_jit5 || r_meas5))
        else $error("jitter flagged on an animation with fewer than two frames");

    a_short_anim_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !r_meas5) |-> (r_range5 == '0 && r_sum5 == '0))
        else $error("range or change reported for an animation with fewer than two frames");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_FRAMES))
        else $error("frame count beyond its limit");

    a_empty_cell_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_has |-> (r_top == '1 && r_bot == '0))
        else $error("cell bounds not cleared while no opaque pixel seen");

endmodule

>>> bench/tb_sprite_height_jitter_check_core.sv
// Self-checking testbench for the sprite height jitter check core.
module tb_sprite_height_jitter_check_core;

    typedef struct packed {
        logic                         measured;
        logic [shjc_pkg::RANGE_W-1:0] height_range;
        logic [shjc_pkg::SUM_W-1:0]   total_change;
        logic                         jitter;
        logic [shjc_pkg::CNT_W-1:0]   frames_counted;
    } t_report;

    // Height tracker that mirrors the block: cell extent, animation statistics,
    // and the queue of jitter reports still owed by the block.
    class jitter_scoreboard;
        logic [shjc_pkg::CFG_W-1:0]    alpha_thr;
        logic [shjc_pkg::CFG_W-1:0]    ign_range;
        logic [shjc_pkg::CFG_W-1:0]    ratio_halves;
        logic [shjc_pkg::ROW_W-1:0]    top_row;
        logic [shjc_pkg::ROW_W-1:0]    bottom_row;
        logic                          cell_opaque;
        logic [shjc_pkg::HEIGHT_W-1:0] prev_height;
        logic [shjc_pkg::HEIGHT_W-1:0] low_height;
        logic [shjc_pkg::HEIGHT_W-1:0] high_height;
        logic [shjc_pkg::SUM_W-1:0]    change_sum;
        logic [shjc_pkg::CNT_W-1:0]    frame_cnt;
        t_report                       owed_reports[$];
        int                            errors;
        int                            reports_seen;
        int                            jitter_seen;

        function new();
            alpha_thr    = shjc_pkg::ALPHA_THR_RST;
            ign_range    = shjc_pkg::IGN_RANGE_RST;
            ratio_halves = shjc_pkg::RATIO_RST;
            clear_cell();
            clear_animation();
            errors       = 0;
            reports_seen = 0;
            jitter_seen  = 0;
        endfunction

        function void clear_cell();
            top_row     = '1;
            bottom_row  = '0;
            cell_opaque = 1'b0;
        endfunction

        function void clear_animation();
            prev_height = '0;
            low_height  = '0;
            high_height = '0;
            change_sum  = '0;
            frame_cnt   = '0;
        endfunction

        function void set_reg(shjc_pkg::t_cfg_idx idx, logic [shjc_pkg::CFG_W-1:0] value);
            case (idx)
                shjc_pkg::CFG_ALPHA_THR: alpha_thr    = value;
                shjc_pkg::CFG_IGN_RANGE: ign_range    = value;
                shjc_pkg::CFG_RATIO:     ratio_halves = value;
                default: ;
            endcase
        endfunction

        // Fold the finished cell into the animation statistics.
        function void close_cell();
            logic [shjc_pkg::HEIGHT_W-1:0] h;
            int                            delta;
            int                            sum;
            if (cell_opaque) begin
                h = {1'b0, bottom_row} - {1'b0, top_row} + 1'b1;
                if (frame_cnt == 0) begin
                    low_height  = h;
                    high_height = h;
                end else begin
                    delta = (h >= prev_height) ? int'(h) - int'(prev_height)
                                               : int'(prev_height) - int'(h);
                    if (h < low_height)  low_height  = h;
                    if (h > high_height) high_height = h;
                    sum = int'(change_sum) + delta;
                    change_sum = (sum > int'(shjc_pkg::SUM_MAX)) ? shjc_pkg::SUM_MAX
                                                                 : sum[shjc_pkg::SUM_W-1:0];
                end
                prev_height = h;
                if (frame_cnt < shjc_pkg::MAX_FRAMES_DEF) frame_cnt = frame_cnt + 1'b1;
            end
            clear_cell();
        endfunction

        function void note_pixel(logic [shjc_pkg::PIX_W-1:0] alpha,
                                 logic [shjc_pkg::ROW_W-1:0] row,
                                 logic in_sheet, logic end_cell, logic end_anim);
            t_report rpt;
            int      span;
            if (in_sheet && int'(row) < shjc_pkg::CELL_HEIGHT_MAX_DEF && alpha >= alpha_thr)
            begin
                if (row < top_row)    top_row    = row;
                if (row > bottom_row) bottom_row = row;
                cell_opaque = 1'b1;
            end
            if (end_cell || end_anim) close_cell();
            if (end_anim) begin
                span = (high_height >= low_height) ? int'(high_height) - int'(low_height) : 0;
                rpt.measured       = (frame_cnt >= 2);
                rpt.height_range   = span[shjc_pkg::RANGE_W-1:0];
                rpt.total_change   = change_sum;
                rpt.jitter         = rpt.measured && span > int'(ign_range) &&
                                     2 * int'(change_sum) > int'(ratio_halves) * span;
                rpt.frames_counted = frame_cnt;
                owed_reports.push_back(rpt);
                clear_animation();
            end
        endfunction

        function void check_report(t_report got);
            t_report want;
            if (owed_reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report m=%0d r=%0d t=%0d j=%0d f=%0d",
                             got.measured, got.height_range, got.total_change,
                             got.jitter, got.frames_counted);
                return;
            end
            want = owed_reports.pop_front();
            reports_seen++;
            if (want.jitter) jitter_seen++;
            if (got.measured       !== want.measured     ||
                got.height_range   !== want.height_range ||
                got.total_change   !== want.total_change ||
                got.jitter         !== want.jitter       ||
                got.frames_counted !== want.frames_counted) begin
                errors++;
                if (errors <= 10) begin
                    $write("report %0d mismatch: expected m=%0d r=%0d t=%0d j=%0d f=%0d,",
                           reports_seen, want.measured, want.height_range,
                           want.total_change, want.jitter, want.frames_counted);
                    $display(" got m=%0d r=%0d t=%0d j=%0d f=%0d",
                             got.measured, got.height_range, got.total_change,
                             got.jitter, got.frames_counted);
                end
            end
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    shjc_pix_if pix_bus ();
    shjc_cfg_if cfg_bus ();
    shjc_res_if rpt_bus ();

    sprite_height_jitter_check_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus.sink),
        .i_cfg   (cfg_bus.sink),
        .o_res   (rpt_bus.source)
    );

    jitter_scoreboard sb;
    bit               sender_burst;
    int               pixels_sent;
    int               settings_used;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Drive every input to a known value from time zero.
    initial begin
        sb                        = new();
        i_rst_n                   = 1'b0;
        pix_bus.valid             = 1'b0;
        pix_bus.alpha             = '0;
        pix_bus.cell_row          = '0;
        pix_bus.in_sheet          = 1'b0;
        pix_bus.last_in_cell      = 1'b0;
        pix_bus.last_in_animation = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = shjc_pkg::CFG_ALPHA_THR;
        cfg_bus.data              = '0;
        rpt_bus.ready             = 1'b0;
        sender_burst              = 1'b0;
        pixels_sent               = 0;
        settings_used             = 1;
    end

    // Result side back-pressure: stretches of steady ready, random ready, and long stalls.
    initial begin
        int mode;
        int len;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                len = $urandom_range(5, 60);
                repeat (len) begin
                    @(negedge i_clk);
                    rpt_bus.ready = 1'b1;
                end
            end else if (mode < 9) begin
                len = $urandom_range(5, 60);
                repeat (len) begin
                    @(negedge i_clk);
                    rpt_bus.ready = ($urandom_range(0, 3) != 0);
                end
            end else begin
                len = $urandom_range(20, 60);
                repeat (len) begin
                    @(negedge i_clk);
                    rpt_bus.ready = 1'b0;
                end
            end
        end
    end

    // Check every report transaction against the oldest owed report.
    always @(posedge i_clk) begin
        t_report got;
        if (i_rst_n && rpt_bus.valid && rpt_bus.ready) begin
            got.measured       = rpt_bus.measured;
            got.height_range   = rpt_bus.height_range;
            got.total_change   = rpt_bus.total_change;
            got.jitter         = rpt_bus.jitter;
            got.frames_counted = rpt_bus.frames_counted;
            sb.check_report(got);
        end
    end

    // Send one pixel transaction, with an optional idle gap ahead of it.
    task automatic send_pixel(input logic [shjc_pkg::PIX_W-1:0] alpha,
                              input logic [shjc_pkg::ROW_W-1:0] row,
                              input logic in_sheet, input logic end_cell,
                              input logic end_anim);
        int pick;
        int gap;
        gap = 0;
        if (!sender_burst) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92)      gap = $urandom_range(8, 30);
            else if (pick >= 65) gap = $urandom_range(1, 3);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            pix_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_bus.valid             = 1'b1;
        pix_bus.alpha             = alpha;
        pix_bus.cell_row          = row;
        pix_bus.in_sheet          = in_sheet;
        pix_bus.last_in_cell      = end_cell;
        pix_bus.last_in_animation = end_anim;
        do @(posedge i_clk); while (!pix_bus.ready);
        sb.note_pixel(alpha, row, in_sheet, end_cell, end_anim);
        pixels_sent++;
    endtask

    // Hold the pixel side idle until every owed report has arrived, then let the
    // pipeline empty out cells that produce no report.
    task automatic drain();
        @(negedge i_clk);
        pix_bus.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input shjc_pkg::t_cfg_idx idx,
                             input logic [shjc_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic apply_setting(input logic [shjc_pkg::CFG_W-1:0] thr,
                                 input logic [shjc_pkg::CFG_W-1:0] ign,
                                 input logic [shjc_pkg::CFG_W-1:0] ratio);
        drain();
        write_reg(shjc_pkg::CFG_ALPHA_THR, thr);
        write_reg(shjc_pkg::CFG_IGN_RANGE, ign);
        write_reg(shjc_pkg::CFG_RATIO, ratio);
        settings_used++;
    endtask

    // Bias alpha toward the threshold edges and the extremes.
    function automatic logic [shjc_pkg::PIX_W-1:0] pick_alpha(
        logic [shjc_pkg::CFG_W-1:0] thr);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return thr;
            3:       return thr - 1'b1;
            4, 5:    return shjc_pkg::PIX_W'($urandom_range(0, 255));
            default: return shjc_pkg::PIX_W'($urandom_range(thr, 255));
        endcase
    endfunction

    // One animation: a few cells with random content; some cells empty, and
    // sometimes the animation end closes the last cell on its own.
    task automatic random_animation();
        int                         frames;
        int                         npix;
        int                         base;
        int                         span;
        bit                         empty_cell;
        bit                         last_frame;
        bit                         last_pix;
        logic [shjc_pkg::ROW_W-1:0] row;
        frames       = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        sender_burst = ($urandom_range(0, 3) == 0);
        // Drop in stray pixels now and then: broken sequences with random marks.
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3))
                send_pixel(shjc_pkg::PIX_W'($urandom_range(0, 255)),
                           shjc_pkg::ROW_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 5) == 0);
        end
        if (frames == 0) begin
            send_pixel(pick_alpha(sb.alpha_thr), shjc_pkg::ROW_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        for (int f = 0; f < frames; f++) begin
            npix       = $urandom_range(1, 5);
            empty_cell = ($urandom_range(0, 6) == 0);
            base       = $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                0:       span = 256;
                1, 2, 3: span = $urandom_range(1, 64);
                default: span = $urandom_range(1, 12);
            endcase
            last_frame = (f == frames - 1);
            for (int p = 0; p < npix; p++) begin
                last_pix = (p == npix - 1);
                row      = shjc_pkg::ROW_W'(base + int'($urandom_range(0, span - 1)));
                send_pixel(pick_alpha(sb.alpha_thr), row,
                           empty_cell ? 1'b0 : ($urandom_range(0, 9) != 0),
                           last_pix && !(last_frame && $urandom_range(0, 3) == 0),
                           last_frame && last_pix);
            end
        end
    endtask

    // Seventy frames alternating between full height and a single row: drives
    // the frame count and the change sum into saturation.
    task automatic long_animation();
        sender_burst = 1'b0;
        for (int f = 0; f < 70; f++) begin
            if (f % 2 == 0) begin
                send_pixel('1, '0, 1'b1, 1'b0, 1'b0);
                send_pixel('1, '1, 1'b1, 1'b1, f == 69);
            end else begin
                send_pixel('1, shjc_pkg::ROW_W'($urandom_range(0, 255)), 1'b1, 1'b1, f == 69);
            end
        end
    endtask

    task automatic random_phase(input int quota, input bit with_long);
        int start;
        start = pixels_sent;
        if (with_long) long_animation();
        while (pixels_sent - start < quota) random_animation();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset settings (threshold 24, ignorable 3, ratio 3.5).
        sender_burst = 1'b1;
        // Animation with no frame at all.
        send_pixel('0, '0, 1'b1, 1'b1, 1'b1);
        // Threshold edges, marks on an ignored pixel, full-height cell, empty
        // cell, and an animation end that closes its own cell.
        send_pixel(8'd23, 8'd5, 1'b1, 1'b0, 1'b0);
        send_pixel(8'd24, 8'd10, 1'b1, 1'b0, 1'b0);
        send_pixel('1, '1, 1'b0, 1'b1, 1'b0);
        send_pixel('1, '0, 1'b1, 1'b0, 1'b0);
        send_pixel('1, '1, 1'b1, 1'b1, 1'b0);
        send_pixel('0, 8'd100, 1'b1, 1'b1, 1'b0);
        send_pixel(8'd200, 8'd50, 1'b1, 1'b0, 1'b1);
        // Single counted frame; animation end carried by an ignored pixel.
        send_pixel('1, 8'd7, 1'b1, 1'b1, 1'b0);
        send_pixel('0, '0, 1'b0, 1'b0, 1'b1);
        // Heights 10, 1, 10, 1, 10, 1, 10: range above the limit and a large change sum.
        send_pixel('1, 8'd0, 1'b1, 1'b0, 1'b0);
        send_pixel('1, 8'd9, 1'b1, 1'b1, 1'b0);
        send_pixel('1, 8'd3, 1'b1, 1'b1, 1'b0);
        send_pixel('1, 8'd20, 1'b1, 1'b0, 1'b0);
        send_pixel('1, 8'd29, 1'b1, 1'b1, 1'b0);
        send_pixel('1, 8'd40, 1'b1, 1'b1, 1'b0);
        send_pixel('1, 8'd50, 1'b1, 1'b0, 1'b0);
        send_pixel('1, 8'd59, 1'b1, 1'b1, 1'b0);
        send_pixel('1, 8'd70, 1'b1, 1'b1, 1'b0);
        send_pixel('1, 8'd80, 1'b1, 1'b0, 1'b0);
        send_pixel('1, 8'd89, 1'b1, 1'b1, 1'b1);

        // Random part across several settings, extremes included; each change
        // waits for the block to go idle.
        random_phase(130, 1'b0);
        apply_setting(8'd0, 8'd0, 8'd0);
        random_phase(130, 1'b1);
        apply_setting(8'd255, 8'd255, 8'd255);
        random_phase(120, 1'b0);
        apply_setting(8'd128, 8'd1, 8'd2);
        random_phase(130, 1'b0);
        apply_setting(shjc_pkg::CFG_W'($urandom_range(0, 255)),
                      shjc_pkg::CFG_W'($urandom_range(0, 15)),
                      shjc_pkg::CFG_W'($urandom_range(0, 20)));
        random_phase(130, 1'b1);
        apply_setting(8'd1, 8'd0, 8'd7);
        random_phase(130, 1'b0);

        drain();
        $display("covered %0d pixels, %0d reports (%0d flagged) over %0d register settings",
                 pixels_sent, sb.reports_seen, sb.jitter_seen, settings_used);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_sprite_height_jitter_check_core: clean");
        end else begin
            $display("%0d mismatches, %0d reports never arrived", sb.errors, sb.pending());
            $display("tb_sprite_height_jitter_check_core: errors");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("timeout with %0d reports outstanding", sb.pending());
        $display("tb_sprite_height_jitter_check_core: errors");
        $finish;
    end

endmodule
